>>> design/battery_voltage_averager_monitor_assert.svh
// ----------------------------------------------------------------------------
// Battery voltage averager monitor assertion macros
// Concurrent assertion forms for the averager top-level design file.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_AVERAGER_MONITOR_ASSERT_SVH
`define BATTERY_VOLTAGE_AVERAGER_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BVAM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bvam assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BVAM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bvam assertion failed");

`endif

>>> design/bvam_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage averager monitor package
// Fixed widths, register indexes and shared types of the averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bvam_pkg;

   localparam int MV_W     = 14;
   localparam int TICK_W   = 8;
   localparam int CSR_A_W  = 2;
   localparam int RSP_W    = 24;
   localparam int RSP_PAD  = RSP_W - MV_W - 3;

   localparam logic [MV_W-1:0] MV_NUMERATOR = 14'd9680;

   localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 8'd50;
   localparam logic [MV_W-1:0]   LOW_LIMIT_RST   = 14'd2700;
   localparam logic [MV_W-1:0]   HIGH_LIMIT_RST  = 14'd4000;

   localparam logic [CSR_A_W-1:0] CSR_TICK_PERIOD = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_LOW_LIMIT   = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_HIGH_LIMIT  = 2'd2;

   // Status of the serial divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
   } div_sts_type;

   // Ring control from the sequencer.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_ctl_type;

endpackage

`default_nettype wire

>>> design/bvam_ring.sv
// ----------------------------------------------------------------------------
// Sample ring with running sum
// Holds the sample window in a memory and keeps the sum of its entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvam_ring #(
   parameter int DEPTH = 8,
   parameter int SB    = 12
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire bvam_pkg::ring_ctl_type    ctl,
   input  wire [SB-1:0]                   sample,
   output logic [SB+$clog2(DEPTH)-1:0]    sum,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int SUM_W = SB + $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [SB-1:0]    ring_mem [DEPTH];
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             filled_ff, filled_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SB-1:0]    rd_data_ff;
   logic             rd_vld_ff;
   logic [SB-1:0]    old_val;

   // An entry never written reads as zero.
   assign old_val = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      vld_in    = vld_ff;
      idx_in    = idx_ff;
      filled_in = filled_ff;
      sum_in    = sum_ff;
      if (ctl.wr_en) begin
         vld_in[idx_ff] = 1'b1;
         sum_in = sum_ff - SUM_W'(old_val) + SUM_W'(sample);
         if (idx_ff == IDX_W'(DEPTH - 1)) begin
            idx_in    = '0;
            filled_in = 1'b1;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         idx_ff    <= '0;
         filled_ff <= 1'b0;
         sum_ff    <= '0;
      end else begin
         vld_ff    <= vld_in;
         idx_ff    <= idx_in;
         filled_ff <= filled_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= ring_mem[idx_ff];
         rd_vld_ff  <= vld_ff[idx_ff];
      end
      if (ctl.wr_en) begin
         ring_mem[idx_ff] <= sample;
      end
   end

   assign sum   = sum_ff;
   // Until the first wrap the divisor is the number of entries written.
   assign count = filled_ff ? CNT_W'(DEPTH) : CNT_W'(idx_ff);

endmodule

`default_nettype wire

>>> design/bvam_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle, DW quotient bits in all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvam_div #(
   parameter int DW = 26,
   parameter int VW = 12
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire [DW-1:0]              dividend,
   input  wire [VW-1:0]              divisor,
   output bvam_pkg::div_sts_type     sts,
   output logic [DW-1:0]             quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    dvs_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [VW:0]      rem_sh;
   logic [VW:0]      rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, quo_ff[DW-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits enter below.
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign sts.busy = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> design/battery_voltage_averager_monitor.sv
// Each transfer on the req channel is one tick. A tick that does not reach the
// programmed period, or a timeout on the period tick, goes straight to the
// emit state, which loads its rsp transfer into the output register. A measuring
// tick writes the sample into the window ring and then runs two passes of the
// bit-serial divider (the window average, then the scaling to millivolts),
// each of SAMPLE_BITS + 14 quotient bits, before it reaches the emit state.
// One tick is in work at a time; a new one is taken while the previous rsp
// transfer still waits in the output register.
// ----------------------------------------------------------------------------
// Battery voltage averager monitor
// Window average of converter samples, scaled to millivolts, with a limit check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "battery_voltage_averager_monitor_assert.svh"

module battery_voltage_averager_monitor #(
   parameter int WINDOW_DEPTH = 8,
   parameter int SAMPLE_BITS  = 12
) (
   input  wire                                     clock,
   input  wire                                     reset,
   // req_tdata: sample [SAMPLE_BITS-1:0], sample_valid, zero fill
   input  wire                                     req_tvalid,
   output logic                                    req_tready,
   input  wire [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] req_tdata,
   // rsp_tdata: millivolts [13:0], data_ready, voltage_fault, measured_now,
   // zero fill
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   output logic [bvam_pkg::RSP_W-1:0]              rsp_tdata,
   input  wire                                     csr_we,
   input  wire [bvam_pkg::CSR_A_W-1:0]             csr_addr,
   input  wire [bvam_pkg::MV_W-1:0]                csr_wdata
);

   localparam int SB    = SAMPLE_BITS;
   localparam int MV_W  = bvam_pkg::MV_W;
   localparam int TW    = bvam_pkg::TICK_W;
   localparam int DW    = SB + MV_W;
   localparam int SUM_W = SB + $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_UPD   = 3'd1;
   localparam logic [2:0] ST_DIV1S = 3'd2;
   localparam logic [2:0] ST_DIV1  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DIV2S = 3'd5;
   localparam logic [2:0] ST_DIV2  = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [TW-1:0]           period_ff;
   logic [MV_W-1:0]         low_ff, high_ff;
   logic [TW-1:0]           tick_ff, tick_in;
   logic [TW:0]             tick_next;
   logic [SB-1:0]           sample_ff;
   logic                    meas_ff, meas_in;
   logic [MV_W-1:0]         volt_ff, volt_in;
   logic                    ready_ff, ready_in;
   logic [DW-1:0]           prod_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [bvam_pkg::RSP_W-1:0] rsp_data_ff;
   logic                    req_fire;
   logic                    out_free;
   logic                    period_hit;
   logic                    fault;

   bvam_pkg::ring_ctl_type  ring_ctl;
   logic [SUM_W-1:0]        ring_sum;
   logic [CNT_W-1:0]        ring_cnt;

   bvam_pkg::div_sts_type   div_sts;
   logic                    div_start;
   logic [DW-1:0]           div_dividend;
   logic [SB-1:0]           div_divisor;
   logic [DW-1:0]           div_quo;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // A period of zero acts like one, since the incremented count never
   // falls below it.
   assign tick_next  = {1'b0, tick_ff} + (TW + 1)'(1);
   assign period_hit = !(tick_next < {1'b0, period_ff});

   assign fault = ready_ff && ((volt_ff < low_ff) || (volt_ff > high_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= bvam_pkg::TICK_PERIOD_RST;
         low_ff    <= bvam_pkg::LOW_LIMIT_RST;
         high_ff   <= bvam_pkg::HIGH_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            bvam_pkg::CSR_TICK_PERIOD: period_ff <= csr_wdata[TW-1:0];
            bvam_pkg::CSR_LOW_LIMIT:   low_ff    <= csr_wdata;
            bvam_pkg::CSR_HIGH_LIMIT:  high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      meas_in      = meas_ff;
      volt_in      = volt_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ring_ctl     = '0;
      div_start    = 1'b0;
      div_dividend = {{(DW - SUM_W){1'b0}}, ring_sum};
      div_divisor  = {{(SB - CNT_W){1'b0}}, ring_cnt};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               meas_in = 1'b0;
               if (period_hit) begin
                  tick_in = '0;
                  if (req_tdata[SB]) begin
                     meas_in        = 1'b1;
                     ring_ctl.rd_en = 1'b1;
                     state_in       = ST_UPD;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else begin
                  tick_in  = tick_next[TW-1:0];
                  state_in = ST_EMIT;
               end
            end
         end
         ST_UPD: begin
            ring_ctl.wr_en = 1'b1;
            state_in       = ST_DIV1S;
         end
         ST_DIV1S: begin
            div_start = 1'b1;
            state_in  = ST_DIV1;
         end
         ST_DIV1: begin
            if (!div_sts.busy) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV2S;
         end
         ST_DIV2S: begin
            div_start    = 1'b1;
            div_dividend = prod_ff;
            div_divisor  = {SB{1'b1}};
            state_in     = ST_DIV2;
         end
         ST_DIV2: begin
            if (!div_sts.busy) begin
               volt_in  = div_quo[MV_W-1:0];
               ready_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         meas_ff      <= 1'b0;
         volt_ff      <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         meas_ff      <= meas_in;
         volt_ff      <= volt_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_tdata[SB-1:0];
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= DW'(div_quo[SB-1:0]) * DW'(bvam_pkg::MV_NUMERATOR);
      end
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_data_ff <= {{bvam_pkg::RSP_PAD{1'b0}}, meas_ff, fault, ready_ff, volt_ff};
      end
   end

   bvam_ring #(
      .DEPTH (WINDOW_DEPTH),
      .SB    (SB)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ring_ctl),
      .sample (sample_ff),
      .sum    (ring_sum),
      .count  (ring_cnt)
   );

   bvam_div #(
      .DW (DW),
      .VW (SB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BVAM_ASSERT_IMP(a_meas_ready, clock, reset, rsp_tvalid && rsp_tdata[MV_W+2], rsp_tdata[MV_W])
   `BVAM_ASSERT_IMP(a_fault_ready, clock, reset, rsp_tvalid && rsp_tdata[MV_W+1], rsp_tdata[MV_W])
   `BVAM_ASSERT_IMP(a_start_idle_div, clock, reset, div_start, !div_sts.busy)
   `BVAM_ASSERT_NXT(a_div2_to_emit, clock, reset, (state_ff == ST_DIV2) && !div_sts.busy, (state_ff == ST_EMIT) && ready_ff)

endmodule

`default_nettype wire

>>> dv/tb_battery_voltage_averager_monitor.sv
// ----------------------------------------------------------------------------
// Battery voltage averager monitor testbench
// Sends ticks through the req stream and checks every rsp transfer against a
// behavioral model of the window average, millivolt scaling and limit check.
// A directed table covers the corner cases. Random phases under several
// register settings follow, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_battery_voltage_averager_monitor;

   localparam int DEPTH = 8;
   localparam int FULL_SCALE = 4095;
   localparam int MV_W = bvam_pkg::MV_W;
   localparam int TICK_W = bvam_pkg::TICK_W;
   localparam int CSR_A_W = bvam_pkg::CSR_A_W;
   localparam logic [CSR_A_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int HOLD_AT_RESULT = 120;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [MV_W-1:0] mv;
      logic            ready;
      logic            fault;
      logic            meas;
   } reading_type;

   typedef struct packed {
      bit                 is_csr;
      logic [CSR_A_W-1:0] addr;
      logic [MV_W-1:0]    wdata;
      logic [11:0]        smp;
      bit                 vld;
      bit                 typed;
      reading_type        want;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [bvam_pkg::RSP_W-1:0] rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_A_W-1:0]   csr_addr = '0;
   logic [MV_W-1:0]      csr_wdata = '0;

   // Model state of the block, kept in step with accepted ticks.
   logic [11:0]          ring [DEPTH];
   logic [2:0]           wr_idx = '0;
   bit                   ring_full = 1'b0;
   logic [TICK_W-1:0]    tick_cnt = '0;
   logic [MV_W-1:0]      mv_store = '0;
   bit                   ready_seen = 1'b0;
   logic [TICK_W-1:0]    cfg_period = bvam_pkg::TICK_PERIOD_RST;
   logic [MV_W-1:0]      cfg_low = bvam_pkg::LOW_LIMIT_RST;
   logic [MV_W-1:0]      cfg_high = bvam_pkg::HIGH_LIMIT_RST;

   reading_type          expected_readings [$];
   step_type             directed_steps [$];
   int                   idle_mode = 1;
   int                   errors = 0;
   int                   ticks_sent = 0;
   int                   results_checked = 0;
   int                   measurements = 0;
   int                   faults_seen = 0;
   int                   periods_used = 1;

   battery_voltage_averager_monitor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL battery_voltage_averager_monitor");
      $finish;
   end

   initial begin
      for (int k = 0; k < DEPTH; k++) ring[k] = '0;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   // One tick through the model; returns the reading the block should give.
   function automatic reading_type predict_tick(input logic [11:0] smp, input bit vld);
      int unsigned total;
      int unsigned avg;
      reading_type r;
      total = 0;
      r.meas = 1'b0;
      if (int'(tick_cnt) + 1 < int'(cfg_period)) begin
         tick_cnt = tick_cnt + 8'd1;
      end else begin
         tick_cnt = '0;
         if (vld) begin
            ring[wr_idx] = smp;
            wr_idx = wr_idx + 3'd1;
            if (wr_idx == 3'd0) ring_full = 1'b1;
            for (int k = 0; k < DEPTH; k++) total += ring[k];
            if (ring_full) avg = total / DEPTH;
            else avg = total / wr_idx;
            mv_store = MV_W'((avg * 9680) / FULL_SCALE);
            ready_seen = 1'b1;
            r.meas = 1'b1;
         end
      end
      r.mv = mv_store;
      r.ready = ready_seen;
      r.fault = ready_seen && (mv_store < cfg_low || mv_store > cfg_high);
      return r;
   endfunction

   function automatic int draw_idle();
      case (idle_mode)
         0: return 0;
         1: return $urandom_range(0, 19);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   function automatic void add_tick(input logic [11:0] smp, input bit vld,
                                    input bit typed, input reading_type want);
      step_type s;
      s = '0;
      s.smp = smp;
      s.vld = vld;
      s.typed = typed;
      s.want = want;
      directed_steps.push_back(s);
   endfunction

   function automatic void add_csr(input logic [CSR_A_W-1:0] addr,
                                   input logic [MV_W-1:0] data);
      step_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.addr = addr;
      s.wdata = data;
      directed_steps.push_back(s);
   endfunction

   task automatic send_tick(input logic [11:0] smp, input bit vld,
                            input bit typed, input reading_type want);
      int gap;
      reading_type pred;
      gap = draw_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, vld, smp};
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = predict_tick(smp, vld);
      expected_readings.push_back(typed ? want : pred);
      ticks_sent++;
   endtask

   // Registers change only once every pending reading has been delivered.
   task automatic write_csr(input logic [CSR_A_W-1:0] addr, input logic [MV_W-1:0] data);
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         bvam_pkg::CSR_TICK_PERIOD: begin
            cfg_period = data[TICK_W-1:0];
            periods_used++;
         end
         bvam_pkg::CSR_LOW_LIMIT: cfg_low = data;
         bvam_pkg::CSR_HIGH_LIMIT: cfg_high = data;
         default: ;
      endcase
   endtask

   initial begin : rsp_side
      int stall;
      reading_type got;
      reading_type want;
      wait (reset == 1'b0);
      forever begin
         // A single long hold-off lets the block fill up and stall its input.
         stall = (results_checked == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_idle();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = {rsp_tdata[MV_W-1:0], rsp_tdata[MV_W], rsp_tdata[MV_W+1], rsp_tdata[MV_W+2]};
         results_checked++;
         if (got.meas === 1'b1) measurements++;
         if (got.fault === 1'b1) faults_seen++;
         if (expected_readings.size() == 0) begin
            report_mismatch("rsp transfer with no reading expected");
         end else begin
            want = expected_readings.pop_front();
            if (got.mv !== want.mv)
               report_mismatch($sformatf("millivolts %0d, expected %0d", got.mv, want.mv));
            if (got.ready !== want.ready)
               report_mismatch($sformatf("data_ready %b, expected %b", got.ready, want.ready));
            if (got.fault !== want.fault)
               report_mismatch($sformatf("voltage_fault %b, expected %b (mv %0d)",
                                         got.fault, want.fault, want.mv));
            if (got.meas !== want.meas)
               report_mismatch($sformatf("measured_now %b, expected %b", got.meas, want.meas));
         end
      end
   end

   initial begin : stimulus
      logic [TICK_W-1:0] phase_period [8];
      logic [MV_W-1:0] lo;
      logic [MV_W-1:0] hi;
      logic [MV_W-1:0] swap;
      int n_items;
      step_type s;

      phase_period = '{8'd1, 8'd2, 8'd0, 8'd3, 8'd1, 8'd255, 8'd6, 8'd1};

      // Reset defaults: period 50, so the first tick only counts.
      add_tick(12'hFFF, 1'b1, 1'b1, {14'd0, 1'b0, 1'b0, 1'b0});
      add_csr(bvam_pkg::CSR_TICK_PERIOD, 14'd1);
      // First measurement at full scale averages over one entry only.
      add_tick(12'hFFF, 1'b1, 1'b1, {14'd9680, 1'b1, 1'b1, 1'b1});
      add_tick(12'h000, 1'b1, 1'b0, '0);
      // Timeout on the period tick leaves the reading as it was.
      add_tick(12'hFFF, 1'b0, 1'b0, '0);
      add_tick(12'h555, 1'b1, 1'b0, '0);
      add_tick(12'hAAA, 1'b1, 1'b0, '0);
      add_tick(12'h800, 1'b1, 1'b0, '0);
      add_tick(12'h7FF, 1'b1, 1'b0, '0);
      add_tick(12'h001, 1'b1, 1'b0, '0);
      add_tick(12'hFFE, 1'b1, 1'b0, '0);
      // The ring has wrapped; this one overwrites the oldest entry.
      add_tick(12'h123, 1'b1, 1'b0, '0);
      add_csr(bvam_pkg::CSR_LOW_LIMIT, 14'd0);
      add_csr(bvam_pkg::CSR_HIGH_LIMIT, 14'd9680);
      add_tick(12'hFFF, 1'b1, 1'b0, '0);
      // Low limit above the high limit is taken as it stands.
      add_csr(bvam_pkg::CSR_LOW_LIMIT, 14'd9680);
      add_csr(bvam_pkg::CSR_HIGH_LIMIT, 14'd0);
      add_tick(12'h000, 1'b1, 1'b0, '0);
      add_csr(CSR_UNMAPPED, 14'h3FFF);
      // A period of zero acts like one.
      add_csr(bvam_pkg::CSR_TICK_PERIOD, 14'd0);
      add_tick(12'h3C0, 1'b1, 1'b0, '0);
      add_tick(12'h000, 1'b0, 1'b0, '0);
      // Bits above the period width are dropped, so this sets 10.
      add_csr(bvam_pkg::CSR_TICK_PERIOD, 14'h3F0A);
      repeat (5) add_tick(12'hFFF, 1'b1, 1'b0, '0);
      // Lowering the period below the running count forces a period tick.
      add_csr(bvam_pkg::CSR_TICK_PERIOD, 14'd2);
      add_tick(12'hFFF, 1'b1, 1'b0, '0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         s = directed_steps[i];
         if (s.is_csr) write_csr(s.addr, s.wdata);
         else send_tick(s.smp, s.vld, s.typed, s.want);
      end

      for (int p = 0; p < 8; p++) begin
         lo = MV_W'($urandom_range(0, 9680));
         hi = MV_W'($urandom_range(lo, 9680));
         if (p == 6) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         write_csr(bvam_pkg::CSR_TICK_PERIOD, {6'b000000, phase_period[p]});
         write_csr(bvam_pkg::CSR_LOW_LIMIT, lo);
         write_csr(bvam_pkg::CSR_HIGH_LIMIT, hi);
         idle_mode = p % 3;
         n_items = (phase_period[p] == 8'd255) ? 30 : 60;
         repeat (n_items)
            send_tick(12'($urandom_range(0, 4095)), $urandom_range(0, 9) != 0, 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Run covered %0d ticks and %0d checked rsp transfers, %0d of them measurements",
               ticks_sent, results_checked, measurements);
      $display("and %0d with a window fault, over %0d tick period settings including 0 and 255.",
               faults_seen, periods_used);
      if (errors == 0) begin
         $display("PASS battery_voltage_averager_monitor");
      end else begin
         $display("FAIL battery_voltage_averager_monitor");
      end
      $finish;
   end

endmodule
